>>> rtl/core/itp_pkg.sv
// Package for the infix-to-postfix converter: sizes, characters, priorities and shared types.
package itp_pkg;

  // Operator stack depth and the widths that follow from it.
  localparam int STACK_DEPTH  = 32;
  localparam int SP_W         = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W       = $clog2(STACK_DEPTH);
  localparam int RESULT_LIMIT = 34;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);
  localparam int PRIO_W       = 4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_END     = 8'h3D;  // '='
  localparam logic [7:0] CH_LPAREN  = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN  = 8'h29;  // ')'
  localparam logic [7:0] CH_POW     = 8'h5E;  // '^'
  localparam logic [7:0] CH_MUL     = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV     = 8'h2F;  // '/'
  localparam logic [7:0] CH_MOD     = 8'h25;  // '%'
  localparam logic [7:0] CH_ADD     = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB     = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // One input item.
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_expression;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       overflow;
  } out_t;

  // Result request from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    out_t data;
  } emit_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_EMIT
  } state_t;

  // True for a character that enters the operator logic.
  function automatic logic is_op(input logic [7:0] ch);
    logic r;
    case (ch)
      CH_LPAREN, CH_RPAREN, CH_POW, CH_MUL, CH_DIV, CH_MOD, CH_ADD, CH_SUB: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Priority of a character while it sits on the stack.
  function automatic logic [PRIO_W-1:0] stack_prio(input logic [7:0] ch);
    logic [PRIO_W-1:0] p;
    case (ch)
      CH_LPAREN:              p = PRIO_W'(1);
      CH_POW:                 p = PRIO_W'(7);
      CH_MUL, CH_DIV, CH_MOD: p = PRIO_W'(5);
      CH_ADD, CH_SUB:         p = PRIO_W'(3);
      CH_RPAREN:              p = PRIO_W'(8);
      default:                p = PRIO_W'(0);
    endcase
    return p;
  endfunction

  // Priority of a character as it arrives.
  function automatic logic [PRIO_W-1:0] incoming_prio(input logic [7:0] ch);
    logic [PRIO_W-1:0] p;
    case (ch)
      CH_LPAREN:              p = PRIO_W'(8);
      CH_POW:                 p = PRIO_W'(6);
      CH_MUL, CH_DIV, CH_MOD: p = PRIO_W'(4);
      CH_ADD, CH_SUB:         p = PRIO_W'(2);
      CH_RPAREN:              p = PRIO_W'(1);
      default:                p = PRIO_W'(0);
    endcase
    return p;
  endfunction

endpackage

>>> rtl/core/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix converter: input channel, sequencer and output register.
//
// One character is taken per input transfer and the input stalls until its work is done.
// Every item is transferred in the idle state. A digit then hands its result over from the
// emit state, and an ignored character takes nothing more. An operator passes through the
// read state (address) and the compare state (registered read data of the stack RAM) for
// each stack entry it examines, and through the emit state for each popped operator sent
// out. An item with end_of_expression set adds the same for the flush of the remaining
// stack, the end mark included, and an emit of the newline terminator. Results wait in an
// output register, so output stalls only hold the sequencer at its next result. No clearing
// pass follows reset: the bottom stack entry is the end mark by construction.
module infix_to_postfix_converter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  itp_pkg::in_t  in_data,
  output logic          in_stall,
  output logic          out_valid,
  output itp_pkg::out_t out_data,
  input  logic          out_stall
);
  import itp_pkg::*;

  emit_t emit;
  logic  slot_free;
  logic  out_valid_r, out_valid_nxt;
  out_t  out_data_r, out_data_nxt;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .emit     (emit),
    .slot_free(slot_free)
  );

  // The output register takes a new result once the held one is transferred.
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit.valid && slot_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit.data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/itp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/itp_ctrl.sv
// Sequencer of the converter: operator stack, priority compare and result requests.
module itp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  itp_pkg::in_t   in_data,
  output logic           in_stall,
  output itp_pkg::emit_t emit,
  input  logic           slot_free
);
  import itp_pkg::*;

  state_t            state_r, state_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [7:0]        cur_ch_r, cur_ch_nxt;
  logic [PRIO_W-1:0] inc_r, inc_nxt;
  logic              eoe_r, eoe_nxt;
  logic              endph_r, endph_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        pend_sym_r, pend_sym_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              pend_pop_r, pend_pop_nxt;
  logic              rd_zero_r, rd_zero_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [7:0]        top_ch;
  logic [PRIO_W-1:0] top_prio;
  logic              done;

  // Stack storage; the bottom entry is never written, and reads of it are bypassed to the end mark.
  itp_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cur_ch_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign top_ch    = rd_zero_r ? CH_END : ram_rdata;
  assign top_prio  = stack_prio(top_ch);
  assign ram_raddr = ADDR_W'(sp_r - SP_W'(1));
  assign ram_waddr = sp_r[ADDR_W-1:0];
  assign in_stall  = (state_r != S_IDLE);

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= SP_W'(1);
      eoe_r   <= 1'b0;
      endph_r <= 1'b0;
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      eoe_r   <= eoe_nxt;
      endph_r <= endph_nxt;
      ovf_r   <= ovf_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    cur_ch_r    <= cur_ch_nxt;
    inc_r       <= inc_nxt;
    pend_sym_r  <= pend_sym_nxt;
    pend_last_r <= pend_last_nxt;
    pend_pop_r  <= pend_pop_nxt;
    rd_zero_r   <= rd_zero_nxt;
  end

  // Next state, stack updates and result requests.
  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    cur_ch_nxt    = cur_ch_r;
    inc_nxt       = inc_r;
    eoe_nxt       = eoe_r;
    endph_nxt     = endph_r;
    ovf_nxt       = ovf_r;
    cnt_nxt       = cnt_r;
    pend_sym_nxt  = pend_sym_r;
    pend_last_nxt = pend_last_r;
    pend_pop_nxt  = pend_pop_r;
    rd_zero_nxt   = rd_zero_r;
    ram_we        = 1'b0;
    emit          = '0;
    done          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt   = '0;
          eoe_nxt   = in_data.end_of_expression;
          endph_nxt = 1'b0;
          if (in_data.character inside {[CH_ZERO:CH_NINE]}) begin
            pend_sym_nxt  = in_data.character;
            pend_last_nxt = 1'b0;
            pend_pop_nxt  = 1'b0;
            state_nxt     = S_EMIT;
          end else if (is_op(in_data.character)) begin
            cur_ch_nxt = in_data.character;
            inc_nxt    = incoming_prio(in_data.character);
            state_nxt  = S_READ;
          end else begin
            done = 1'b1;
          end
        end
      end

      S_READ: begin
        // Address the top entry; the data comes back next cycle.
        if (sp_r == '0) begin
          done = 1'b1;
        end else begin
          rd_zero_nxt = (sp_r == SP_W'(1));
          state_nxt   = S_CMP;
        end
      end

      S_CMP: begin
        if (top_prio < inc_r) begin
          if (sp_r < SP_W'(STACK_DEPTH)) begin
            ram_we = 1'b1;
            sp_nxt = sp_r + SP_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          done = 1'b1;
        end else if (top_prio > inc_r) begin
          sp_nxt        = sp_r - SP_W'(1);
          pend_sym_nxt  = top_ch;
          pend_last_nxt = 1'b0;
          pend_pop_nxt  = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          sp_nxt = sp_r - SP_W'(1);
          done   = 1'b1;
        end
      end

      S_EMIT: begin
        // Results past the per-item limit are dropped without waiting.
        if (cnt_r < CNT_W'(RESULT_LIMIT)) begin
          emit.valid         = 1'b1;
          emit.data.symbol   = pend_sym_r;
          emit.data.last     = pend_last_r;
          emit.data.overflow = ovf_r;
        end
        if (slot_free || !(cnt_r < CNT_W'(RESULT_LIMIT))) begin
          if (cnt_r < CNT_W'(RESULT_LIMIT)) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (pend_last_r) begin
            sp_nxt    = SP_W'(1);
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else if (pend_pop_r) begin
            state_nxt = S_READ;
          end else begin
            done = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // End of one character's work: start the flush, close the output or go idle.
    if (done) begin
      if (endph_nxt) begin
        pend_sym_nxt  = CH_NEWLINE;
        pend_last_nxt = 1'b1;
        pend_pop_nxt  = 1'b0;
        state_nxt     = S_EMIT;
      end else if (eoe_nxt) begin
        endph_nxt  = 1'b1;
        cur_ch_nxt = CH_END;
        inc_nxt    = '0;
        state_nxt  = S_READ;
      end else begin
        state_nxt = S_IDLE;
      end
    end
  end

`ifndef SYNTHESIS
  // The stack pointer never passes the depth.
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // Between items the end mark is always on the stack.
  a_idle_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (sp_r != '0))
    else $error("stack empty between items");

  // A push is only written while there is room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (sp_r < SP_W'(STACK_DEPTH)))
    else $error("push onto a full stack");

  // After the terminator transfer the stack is reseeded and the block is idle.
  a_last_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && emit.data.last && slot_free) |=>
      (state_r == S_IDLE && sp_r == SP_W'(1) && !ovf_r))
    else $error("no reseed after terminator");
`endif

endmodule
